FILE: src/tga_pkg.sv
// Package for the TGA RLE pixel decoder: item types, config types and constants.
// Used by tga_front, tga_back and tga_rle_pixel_decoder_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tga_pkg;

    localparam int unsigned CAP_W      = 25;
    localparam int unsigned UNUSED_W   = 26;
    localparam int unsigned BPP_W      = 3;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0]          HDR_REPEAT_BIT = 8'h80;
    localparam logic [7:0]          HDR_COUNT_MASK = 8'h7f;
    localparam logic [BPP_W-1:0]    BPP_RESET      = 3'd3;
    localparam logic [BPP_W-1:0]    BPP_MAX        = 3'd4;
    localparam logic [UNUSED_W-1:0] UNUSED_MAX     = {UNUSED_W{1'b1}};

    // configuration register indexes
    localparam logic CFG_BYTES_PER_PIXEL = 1'b0;
    localparam logic CFG_CAPACITY_PIXELS = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0]         pixel_value;
        logic [7:0]          run_length;
        logic                image_done;
        logic [UNUSED_W-1:0] unused_bytes;
    } out_item_t;

    // queue entry: source byte plus its header decode
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       hdr_repeat;
        logic [7:0] hdr_count;
    } q_item_t;

    // control from config registers to the back end
    typedef struct packed {
        logic [1:0]       width_m1;
        logic             cap_load;
        logic [CAP_W-1:0] cap_value;
    } back_cfg_t;

endpackage
`default_nettype wire

FILE: src/tga_front.sv
// Front end of the TGA RLE decoder: accepts source bytes, decodes header fields,
// and holds them in a two-entry queue. Depends on tga_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tga_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire tga_pkg::in_item_t  in_data,
    output logic                    q_valid,
    output tga_pkg::q_item_t        q_item,
    input  wire logic               q_pop
);

    tga_pkg::q_item_t mem_reg [tga_pkg::QUEUE_DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    tga_pkg::q_item_t new_item;

    assign in_stall = (count_reg == 2'(tga_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.data_byte  = in_data.data_byte;
        new_item.last_byte  = in_data.last_byte;
        new_item.hdr_repeat = (in_data.data_byte & tga_pkg::HDR_REPEAT_BIT) != 8'd0;
        new_item.hdr_count  = (in_data.data_byte & tga_pkg::HDR_COUNT_MASK) + 8'd1;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = (q_pop && q_valid) ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !(q_pop && q_valid))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop && q_valid)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/tga_back.sv
// Back end of the TGA RLE decoder: packet/pixel state, capacity and unused-byte
// counting, and the output register. Depends on tga_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tga_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tga_pkg::back_cfg_t cfg,
    input  wire logic               q_valid,
    input  wire tga_pkg::q_item_t   q_item,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output tga_pkg::out_item_t      out_data
);

    logic                         in_pkt_reg, in_pkt_next;
    logic                         rep_reg, rep_next;
    logic [7:0]                   left_reg, left_next;
    logic [1:0]                   bip_reg, bip_next;
    logic [31:0]                  asm_reg, asm_next;
    logic [tga_pkg::CAP_W-1:0]    cap_reg, cap_next;
    logic [tga_pkg::UNUSED_W-1:0] unused_reg, unused_next;
    logic                         hopen_reg, hopen_next;
    logic                         oval_reg, oval_next;
    tga_pkg::out_item_t           oitem_reg, oitem_next;

    logic                         emit;
    logic [31:0]                  pix;
    logic [31:0]                  asm_full;
    logic [7:0]                   run;
    logic [2:0]                   add;
    logic [tga_pkg::UNUSED_W:0]   sum;
    logic [tga_pkg::UNUSED_W-1:0] unused_sat;

    assign q_pop     = q_valid && (!oval_reg || !out_stall);
    assign out_valid = oval_reg;
    assign out_data  = oitem_reg;

    always_comb
    begin
        in_pkt_next = in_pkt_reg;
        rep_next    = rep_reg;
        left_next   = left_reg;
        bip_next    = bip_reg;
        asm_next    = asm_reg;
        cap_next    = cap_reg;
        unused_next = unused_reg;
        hopen_next  = hopen_reg;
        oval_next   = oval_reg && out_stall;
        oitem_next  = oitem_reg;
        emit        = 1'b0;
        pix         = 32'd0;
        run         = 8'd0;
        add         = 3'd0;
        asm_full    = asm_reg | ({24'd0, q_item.data_byte} << {bip_reg, 3'b000});
        sum         = '0;
        unused_sat  = '0;

        if (q_pop)
        begin
            if (cap_reg == '0)
            begin
                add = 3'd1;
            end
            else if (!in_pkt_reg)
            begin
                in_pkt_next = 1'b1;
                rep_next    = q_item.hdr_repeat;
                left_next   = q_item.hdr_count;
                bip_next    = 2'd0;
                asm_next    = 32'd0;
                hopen_next  = 1'b1;
            end
            else if (bip_reg >= cfg.width_m1)
            begin
                pix = asm_full;
                if (rep_reg)
                begin
                    // clamp the repeat run to what the destination still holds
                    run = (cap_reg < {{(tga_pkg::CAP_W-8){1'b0}}, left_reg}) ?
                          cap_reg[7:0] : left_reg;
                    left_next = 8'd0;
                end
                else
                begin
                    run = 8'd1;
                    left_next = left_reg - 8'd1;
                end
                cap_next = cap_reg - {{(tga_pkg::CAP_W-8){1'b0}}, run};
                if (left_next == 8'd0)
                begin
                    in_pkt_next = 1'b0;
                end
                bip_next   = 2'd0;
                asm_next   = 32'd0;
                hopen_next = 1'b0;
                emit       = 1'b1;
            end
            else
            begin
                bip_next = bip_reg + 2'd1;
                asm_next = asm_full;
            end

            // trailing partial pixel and an unserved header count as unused
            if (q_item.last_byte && in_pkt_next && cap_next != '0)
            begin
                add = {1'b0, bip_next} + {2'd0, hopen_next};
            end

            sum = {1'b0, unused_reg} + {{(tga_pkg::UNUSED_W-2){1'b0}}, add};
            unused_sat  = sum[tga_pkg::UNUSED_W] ? tga_pkg::UNUSED_MAX
                                                 : sum[tga_pkg::UNUSED_W-1:0];
            unused_next = unused_sat;

            if (q_item.last_byte)
            begin
                oval_next              = 1'b1;
                oitem_next.pixel_value = pix;
                oitem_next.run_length  = run;
                oitem_next.image_done  = 1'b1;
                oitem_next.unused_bytes = unused_sat;
                in_pkt_next = 1'b0;
                rep_next    = 1'b0;
                left_next   = 8'd0;
                bip_next    = 2'd0;
                asm_next    = 32'd0;
                cap_next    = cfg.cap_value;
                unused_next = '0;
                hopen_next  = 1'b0;
            end
            else if (emit)
            begin
                oval_next              = 1'b1;
                oitem_next.pixel_value = pix;
                oitem_next.run_length  = run;
                oitem_next.image_done  = 1'b0;
                oitem_next.unused_bytes = '0;
            end
        end

        if (cfg.cap_load)
        begin
            cap_next = cfg.cap_value;
        end
    end

    always_ff @(posedge clk)
    begin
        oitem_reg <= oitem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pkt_reg <= 1'b0;
            rep_reg    <= 1'b0;
            left_reg   <= 8'd0;
            bip_reg    <= 2'd0;
            asm_reg    <= 32'd0;
            cap_reg    <= '0;
            unused_reg <= '0;
            hopen_reg  <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            in_pkt_reg <= in_pkt_next;
            rep_reg    <= rep_next;
            left_reg   <= left_next;
            bip_reg    <= bip_next;
            asm_reg    <= asm_next;
            cap_reg    <= cap_next;
            unused_reg <= unused_next;
            hopen_reg  <= hopen_next;
            oval_reg   <= oval_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/tga_rle_pixel_decoder_unit.sv
// TGA RLE pixel decoder, top level: config registers, front queue and back end.
// Path: front queue, then back-end state and output register, then out_valid.
// Throughput: one byte per cycle while the output slot is not held by out_stall;
// the two-entry queue decouples input from output stall.
// Reset: all decode state cleared, bytes_per_pixel = 3, capacity_pixels = 0.
// Depends on tga_pkg, tga_front, tga_back.
`timescale 1ns / 1ps
`default_nettype none
module tga_rle_pixel_decoder_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire tga_pkg::in_item_t           in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output tga_pkg::out_item_t               out_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_index,
    input  wire logic [tga_pkg::CAP_W-1:0]   cfg_data
);

    logic [tga_pkg::BPP_W-1:0] bpp_reg, bpp_next;
    logic [tga_pkg::CAP_W-1:0] cap_cfg_reg, cap_cfg_next;
    logic                      cfg_wr;
    tga_pkg::back_cfg_t        back_cfg;
    logic                      q_valid;
    logic                      q_pop;
    tga_pkg::q_item_t          q_item;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        bpp_next     = bpp_reg;
        cap_cfg_next = cap_cfg_reg;
        if (cfg_wr && cfg_index == tga_pkg::CFG_BYTES_PER_PIXEL)
        begin
            bpp_next = cfg_data[tga_pkg::BPP_W-1:0];
        end
        if (cfg_wr && cfg_index == tga_pkg::CFG_CAPACITY_PIXELS)
        begin
            cap_cfg_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg     <= tga_pkg::BPP_RESET;
            cap_cfg_reg <= '0;
        end
        else
        begin
            bpp_reg     <= bpp_next;
            cap_cfg_reg <= cap_cfg_next;
        end
    end

    // width 0 acts as 1, widths above 4 act as 4
    always_comb
    begin
        if (bpp_reg == '0)
        begin
            back_cfg.width_m1 = 2'd0;
        end
        else if (bpp_reg > tga_pkg::BPP_MAX)
        begin
            back_cfg.width_m1 = 2'd3;
        end
        else
        begin
            back_cfg.width_m1 = 2'(bpp_reg - 3'd1);
        end
        back_cfg.cap_load  = cfg_wr && cfg_index == tga_pkg::CFG_CAPACITY_PIXELS;
        back_cfg.cap_value = back_cfg.cap_load ? cfg_data : cap_cfg_reg;
    end

    tga_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    tga_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (back_cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // input side only backs up while the queue holds items
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> q_valid)
        else $error("input stalled with empty queue");

    // a popped item always frees or replaces the output slot in time
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && out_valid) |-> !out_stall)
        else $error("queue popped while output slot blocked");

    // pixel results carry a nonzero run and no unused count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.image_done) |->
        (out_data.run_length != 8'd0 && out_data.unused_bytes == '0))
        else $error("malformed pixel result");

    // runs never exceed one packet
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.run_length <= 8'd128))
        else $error("run length beyond packet size");

endmodule
`default_nettype wire

FILE: tb/sv/tb_tga_rle_pixel_decoder_unit.sv
// Testbench for tga_rle_pixel_decoder_unit: directed and random RLE byte streams,
// checked against a behavioral decoder in a small scoreboard class.
// Depends on tga_pkg and the decoder RTL.
`timescale 1ns / 1ps
module tb_tga_rle_pixel_decoder_unit;

    localparam int unsigned DRAIN_GAP    = 8;
    localparam int unsigned STALL_BURST  = 300;
    localparam int unsigned QUIET_LIMIT  = 5000;
    localparam int unsigned PHASE_BYTES  = 170;
    localparam int unsigned REPORT_LIMIT = 10;

    class rle_pixel_scoreboard;
        logic [tga_pkg::BPP_W-1:0]    bpp_reg;
        logic [tga_pkg::CAP_W-1:0]    cap_reg;
        bit                           in_pkt;
        bit                           rep_pkt;
        bit                           hdr_open;
        int unsigned                  pix_left;
        int unsigned                  byte_idx;
        logic [31:0]                  assembly;
        int unsigned                  cap_left;
        logic [tga_pkg::UNUSED_W-1:0] unused_cnt;
        tga_pkg::out_item_t           expected_q[$];
        int unsigned                  fail_count;
        int unsigned                  results_seen;
        int unsigned                  images_seen;

        function new();
            bpp_reg = tga_pkg::BPP_RESET;
            cap_reg = '0;
            fail_count = 0;
            results_seen = 0;
            images_seen = 0;
            clear_image();
        endfunction

        function void clear_image();
            in_pkt = 0;
            rep_pkt = 0;
            hdr_open = 0;
            pix_left = 0;
            byte_idx = 0;
            assembly = '0;
            cap_left = 32'(cap_reg);
            unused_cnt = '0;
        endfunction

        function int unsigned width_now();
            if (bpp_reg == 0) return 1;
            if (bpp_reg > tga_pkg::BPP_MAX) return 32'(tga_pkg::BPP_MAX);
            return 32'(bpp_reg);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void load_register(logic idx, logic [tga_pkg::CAP_W-1:0] val);
            if (idx == tga_pkg::CFG_BYTES_PER_PIXEL) begin
                bpp_reg = val[tga_pkg::BPP_W-1:0];
            end else begin
                cap_reg = val;
                cap_left = 32'(val);
            end
        endfunction

        function void add_unused(int unsigned n);
            if (n > 32'(tga_pkg::UNUSED_MAX - unused_cnt))
                unused_cnt = tga_pkg::UNUSED_MAX;
            else
                unused_cnt = unused_cnt + n[tga_pkg::UNUSED_W-1:0];
        endfunction

        function void note_byte(tga_pkg::in_item_t it);
            tga_pkg::out_item_t res;
            bit                 emit;
            int unsigned        run;
            logic [31:0]        pix;
            emit = 0;
            run = 0;
            pix = '0;
            if (cap_left == 0) begin
                add_unused(1);
            end else if (!in_pkt) begin
                in_pkt = 1;
                rep_pkt = (it.data_byte & tga_pkg::HDR_REPEAT_BIT) != 0;
                pix_left = 32'(it.data_byte & tga_pkg::HDR_COUNT_MASK) + 1;
                byte_idx = 0;
                assembly = '0;
                hdr_open = 1;
            end else begin
                assembly = assembly | ({24'h0, it.data_byte} << (8 * byte_idx));
                if (byte_idx + 1 >= width_now()) begin
                    pix = assembly;
                    if (rep_pkt) begin
                        // repeat run is clamped to what the destination still holds
                        run = (pix_left > cap_left) ? cap_left : pix_left;
                        pix_left = 0;
                    end else begin
                        run = 1;
                        pix_left--;
                    end
                    cap_left -= run;
                    if (pix_left == 0) in_pkt = 0;
                    byte_idx = 0;
                    assembly = '0;
                    hdr_open = 0;
                    emit = 1;
                end else begin
                    byte_idx++;
                end
            end
            res.pixel_value = pix;
            res.run_length = 8'(run);
            if (it.last_byte) begin
                // partial pixel bytes and an unfinished header are left unused
                if (in_pkt && cap_left != 0) add_unused(byte_idx + (hdr_open ? 1 : 0));
                res.image_done = 1'b1;
                res.unused_bytes = unused_cnt;
                expected_q.push_back(res);
                clear_image();
            end else if (emit) begin
                res.image_done = 1'b0;
                res.unused_bytes = '0;
                expected_q.push_back(res);
            end
        endfunction

        function void check_result(tga_pkg::out_item_t got);
            tga_pkg::out_item_t want;
            results_seen++;
            if (got.image_done === 1'b1) images_seen++;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result: pixel %08h run %0d done %0b unused %0d",
                             got.pixel_value, got.run_length, got.image_done,
                             got.unused_bytes);
                return;
            end
            want = expected_q.pop_front();
            if (got.pixel_value !== want.pixel_value || got.run_length !== want.run_length ||
                got.image_done !== want.image_done ||
                got.unused_bytes !== want.unused_bytes) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display({"result %0d mismatch: exp pixel %08h run %0d done %0b unused %0d,",
                              " got pixel %08h run %0d done %0b unused %0d"},
                             results_seen, want.pixel_value, want.run_length,
                             want.image_done, want.unused_bytes, got.pixel_value,
                             got.run_length, got.image_done, got.unused_bytes);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    tga_pkg::in_item_t         in_data;
    logic                      out_valid;
    logic                      out_stall;
    tga_pkg::out_item_t        out_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic                      cfg_index;
    logic [tga_pkg::CAP_W-1:0] cfg_data;

    rle_pixel_scoreboard sb = new();

    int unsigned src_idle_pct;
    int unsigned dst_idle_pct;
    bit          stall_burst_req;
    int unsigned bytes_sent;

    logic [tga_pkg::BPP_W-1:0] phase_bpp [6] = '{3'd1, 3'd4, 3'd2, 3'd3, 3'd6, 3'd5};
    logic [tga_pkg::CAP_W-1:0] phase_cap [6] = '{25'd16777216, 25'd40, 25'h1FFFFFF,
                                                 25'd300, 25'd5, 25'd16777216};

    tga_rle_pixel_decoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    end

    // receiver side: random stall, or one long hold-off on request
    initial
    begin
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_burst_req) begin
                out_stall = 1;
                repeat (STALL_BURST) @(negedge clk);
                stall_burst_req = 0;
                out_stall = 0;
            end else begin
                out_stall = ($urandom_range(99) < dst_idle_pct);
            end
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(logic [7:0] b, bit last);
        tga_pkg::in_item_t it;
        it.data_byte = b;
        it.last_byte = last;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        in_data = it;
        do @(posedge clk); while (in_stall);
        sb.note_byte(it);
        bytes_sent++;
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic set_register(logic idx, logic [tga_pkg::CAP_W-1:0] val);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        sb.load_register(idx, val);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // wait for every expected result, then let a byte with no result finish
    task automatic settle();
        in_valid = 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
        @(negedge clk);
    endtask

    // one image: mostly well-formed packets, sometimes noise, last flag
    // usually on the final byte but sometimes cut short; never longer than budget
    task automatic send_image(int unsigned budget);
        logic [7:0]  img[$];
        logic [7:0]  hdr;
        int unsigned w;
        int unsigned cnt;
        int unsigned last_at;
        w = sb.width_now();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) img.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6))
            begin
                cnt = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
                hdr = 8'(cnt) | ($urandom_range(1) ? tga_pkg::HDR_REPEAT_BIT : 8'h00);
                img.push_back(hdr);
                repeat (((hdr & tga_pkg::HDR_REPEAT_BIT) != 0) ? w : w * (cnt + 1))
                    img.push_back(8'($urandom));
            end
        end
        last_at = ($urandom_range(99) < 70) ? img.size() - 1 : $urandom_range(0, img.size() - 1);
        if (last_at >= budget) last_at = budget - 1;
        for (int i = 0; i <= last_at; i++) send_byte(img[i], i == last_at);
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_index = tga_pkg::CFG_BYTES_PER_PIXEL;
        cfg_data = '0;
        stall_burst_req = 0;
        bytes_sent = 0;
        src_idle_pct = 21;
        dst_idle_pct = 51;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset capacity is zero: both bytes are unused
        send_byte(8'h00, 0);
        send_byte(8'hFF, 1);

        // width 0 acts as 1; full 128 repeat, single raw, pixel on the last byte
        settle();
        set_register(tga_pkg::CFG_BYTES_PER_PIXEL, 25'd0);
        set_register(tga_pkg::CFG_CAPACITY_PIXELS, 25'd16777216);
        send_byte(8'hFF, 0);
        send_byte(8'hAB, 0);
        send_byte(8'h00, 0);
        send_byte(8'h55, 0);
        send_byte(8'h81, 0);
        send_byte(8'h00, 1);

        // width 7 acts as 4; repeat clamped to capacity, then bytes ignored
        settle();
        set_register(tga_pkg::CFG_BYTES_PER_PIXEL, 25'd7);
        set_register(tga_pkg::CFG_CAPACITY_PIXELS, 25'd3);
        send_byte(8'h85, 0);
        send_byte(8'hFF, 0);
        send_byte(8'hEE, 0);
        send_byte(8'hDD, 0);
        send_byte(8'h80, 0);
        send_byte(8'h99, 0);
        send_byte(8'h42, 1);

        // capacity rewritten in the middle of an image
        settle();
        set_register(tga_pkg::CFG_BYTES_PER_PIXEL, 25'd2);
        set_register(tga_pkg::CFG_CAPACITY_PIXELS, 25'd5);
        send_byte(8'h02, 0);
        send_byte(8'hAA, 0);
        send_byte(8'hBB, 0);
        send_byte(8'hCC, 0);
        settle();
        set_register(tga_pkg::CFG_CAPACITY_PIXELS, 25'd1);
        send_byte(8'hDD, 0);
        send_byte(8'hEE, 1);

        // trailing partial pixel, then an image that ends on its header
        settle();
        set_register(tga_pkg::CFG_BYTES_PER_PIXEL, 25'd3);
        set_register(tga_pkg::CFG_CAPACITY_PIXELS, 25'd10);
        send_byte(8'h00, 0);
        send_byte(8'h01, 0);
        send_byte(8'h02, 1);
        send_byte(8'h7F, 1);

        for (int ph = 0; ph < 6; ph++)
        begin
            int unsigned goal;
            bit          paused;
            settle();
            set_register(tga_pkg::CFG_BYTES_PER_PIXEL,
                         {{(tga_pkg::CAP_W-tga_pkg::BPP_W){1'b0}}, phase_bpp[ph]});
            set_register(tga_pkg::CFG_CAPACITY_PIXELS, phase_cap[ph]);
            src_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 51 : 0;
            dst_idle_pct = (ph < 2) ? 51 : (ph < 4) ? 21 : 0;
            if (ph == 4) stall_burst_req = 1;
            goal = bytes_sent + PHASE_BYTES;
            paused = 0;
            while (bytes_sent < goal)
            begin
                send_image(goal - bytes_sent);
                if (ph == 2 && !paused && bytes_sent > goal - PHASE_BYTES / 2) begin
                    settle();
                    paused = 1;
                end
            end
        end

        settle();
        $display("covered %0d source bytes and %0d results, %0d of them image ends,",
                 bytes_sent, sb.results_seen, sb.images_seen);
        $display("over pixel widths 0 to 7 and capacities from 0 to 2^25-1");
        if (sb.fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatching results", sb.fail_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
